FILE: design/acd_pkg.sv
`default_nettype none
package acd_pkg;

  // Register map of the configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_ENABLES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN           = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD      = 8'd2;

  localparam int unsigned GAIN_W = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  // tanh argument is Q16 and saturates at 8.0, so 19 quotient bits matter
  localparam int unsigned FRAC_BITS = 19;
  // tanh table entries are Q30
  localparam int unsigned TANH_Q    = 30;
  localparam int unsigned EXP_TERMS = 24;

  typedef struct packed {
    logic advance;
    logic hard_en;
  } stage_ctl_t;

endpackage
`default_nettype wire

FILE: design/acd_front.sv
`default_nettype none
module acd_front #(
  parameter int unsigned W = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire acd_pkg::stage_ctl_t               ctl,
  input  wire logic                              in_valid,
  input  wire logic signed [W-1:0]               sample_in,
  input  wire logic                              last_in,
  input  wire logic [acd_pkg::GAIN_W-1:0]        gain,
  input  wire logic [W-2:0]                      threshold,
  output logic                                   out_valid,
  output logic [W+17:0]                          num,
  output logic [W+1:0]                           tag
);

  logic [W-1:0] x_u;
  logic [W-1:0] mag_in;
  logic [17:0]  gain3;

  logic          v1, v2, v3;
  logic [W-1:0]  mag1, mag2, magh3;
  logic          neg1, neg2, neg3;
  logic          last1, last2, last3;
  logic [W+15:0] p2;
  logic          clip;

  assign x_u    = sample_in;
  assign mag_in = x_u[W-1] ? (~x_u + {{(W-1){1'b0}}, 1'b1}) : x_u;
  assign gain3  = 18'({gain, 1'b0}) + 18'(gain);
  assign clip   = p2 > {9'd0, threshold, 8'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      mag1  <= mag_in;
      neg1  <= x_u[W-1];
      last1 <= last_in;

      p2    <= mag1 * gain;
      mag2  <= mag1;
      neg2  <= neg1;
      last2 <= last1;

      // unclipped product is at most threshold after the shift, so it fits
      if (ctl.hard_en) begin
        magh3 <= clip ? {1'b0, threshold} : p2[W+7:8];
      end else begin
        magh3 <= mag2;
      end
      neg3  <= neg2;
      last3 <= last2;

      num <= magh3 * gain3;
      tag <= {last3, neg3, magh3};
    end
  end

endmodule
`default_nettype wire

FILE: design/acd_div.sv
`default_nettype none
module acd_div #(
  parameter int unsigned W = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire acd_pkg::stage_ctl_t              ctl,
  input  wire logic                             in_valid,
  input  wire logic [W+17:0]                    num,
  input  wire logic [W+1:0]                     tag_in,
  input  wire logic [W-2:0]                     threshold,
  output logic                                  out_valid,
  output logic [acd_pkg::FRAC_BITS-1:0]         quot,
  output logic                                  sat,
  output logic [W+1:0]                          tag_out
);

  localparam int unsigned QB     = acd_pkg::FRAC_BITS;
  localparam int unsigned STAGES = QB + 1;
  localparam int unsigned NW     = W + 26;
  localparam int unsigned TPAD   = NW - (W - 1);

  logic [NW-1:0] rem [0:STAGES];
  logic [QB-1:0] q   [0:STAGES];
  logic [W+1:0]  tg  [0:STAGES];
  logic [STAGES:0] v;
  logic [STAGES:0] st;

  // numerator is 3 * gain * |x| * 256, with |x| taken after any hard clip
  assign rem[0] = {num, 8'd0};
  assign q[0]   = '0;
  assign tg[0]  = tag_in;
  assign v[0]   = in_valid;
  assign st[0]  = 1'b0;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam int unsigned K = QB - j;
    logic [NW-1:0] d;
    logic          ge;

    assign d  = {{TPAD{1'b0}}, threshold} << K;
    assign ge = rem[j] >= d;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (ctl.advance) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        rem[j+1] <= ge ? (rem[j] - d) : rem[j];
        tg[j+1]  <= tg[j];
      end
    end

    if (j == 0) begin : g_sat
      // quotient of 2^19 or more saturates the tanh argument
      always_ff @(posedge clk) begin
        if (ctl.advance) begin
          st[j+1] <= ge;
          q[j+1]  <= q[j];
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (ctl.advance) begin
          st[j+1] <= st[j];
          q[j+1]  <= ge ? (q[j] | (QB'(1) << K)) : q[j];
        end
      end
    end
  end

  assign out_valid = v[STAGES];
  assign quot      = q[STAGES];
  assign sat       = st[STAGES];
  assign tag_out   = tg[STAGES];

endmodule
`default_nettype wire

FILE: design/acd_tanh.sv
`default_nettype none
module acd_tanh #(
  parameter int unsigned W     = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire acd_pkg::stage_ctl_t              ctl,
  input  wire logic                             in_valid,
  input  wire logic [acd_pkg::FRAC_BITS-1:0]    u,
  input  wire logic                             sat,
  input  wire logic [W+1:0]                     tag_in,
  input  wire logic [W-2:0]                     threshold,
  output logic                                  out_valid,
  output logic [W-1:0]                          soft_mag,
  output logic [W+1:0]                          tag_out
);

  localparam int unsigned FB  = acd_pkg::FRAC_BITS;
  localparam int unsigned TQ  = acd_pkg::TANH_Q;
  localparam int unsigned AW  = $clog2(DEPTH + 1);
  localparam int unsigned PAW = FB + AW;
  localparam int unsigned S   = W + 1;
  // reciprocal of 3, exact for every quotient below 2^W
  localparam logic [63:0] RECIP = ((64'd1 << S) / 3) + 64'd1;
  localparam logic [63:0] EXP_Z = (64'd16 << 32) / DEPTH;

  typedef logic [TQ-1:0] rom_t [0:DEPTH];

  // restoring long division, used only while building the table
  function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q, rm;
    q  = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], n[i]};
      if (rm >= d) begin
        rm   = rm - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom(logic [63:0] z);
    logic [63:0] one, term, pos, neg, r, e;
    rom_t tab;
    one  = 64'h1_0000_0000;
    term = one;
    pos  = one;
    neg  = '0;
    // exp(-z) by a truncated Taylor series
    for (int k = 1; k <= acd_pkg::EXP_TERMS; k++) begin
      term = div_u64((term * z) >> 32, 64'(k));
      if ((k & 1) != 0) neg = neg + term;
      else pos = pos + term;
    end
    r = (pos > neg) ? pos - neg : '0;
    if (r > one) r = one;
    e = one;
    for (int i = 0; i <= DEPTH; i++) begin
      tab[i] = TQ'(div_u64((one - e) << 30, one + e));
      e = (e * r) >> 32;
    end
    return tab;
  endfunction

  localparam rom_t TANH_ROM = build_rom(EXP_Z);

  logic [PAW-1:0] p;
  logic [AW-1:0]  addr_a, addr_b;
  logic [TQ-1:0]  step;

  logic [5:0]          v;
  logic [W+1:0]        tg [0:5];
  logic [AW-1:0]       idx_a;
  logic [FB-1:0]       frac_a, frac_b;
  logic                sat_a, sat_b;
  logic [TQ-1:0]       rd_a, rd_b, a_c;
  logic [TQ+FB-1:0]    prod_c;
  logic [TQ-1:0]       t_d;
  logic [W+TQ-2:0]     pt_e;
  logic [W+S-2:0]      qx_f;

  assign p      = PAW'(u) * PAW'(DEPTH);
  assign addr_a = sat_a ? AW'(DEPTH) : idx_a;
  assign addr_b = AW'(idx_a + 1'b1);
  // saturated argument reads the table end with no step
  assign step   = (!sat_b && (rd_b > rd_a)) ? (rd_b - rd_a) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ctl.advance) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      tg[0] <= tag_in;
      for (int i = 1; i < 6; i++) begin
        tg[i] <= tg[i-1];
      end

      idx_a  <= p[PAW-1:FB];
      frac_a <= p[FB-1:0];
      sat_a  <= sat;

      rd_a   <= TANH_ROM[addr_a];
      rd_b   <= TANH_ROM[addr_b];
      frac_b <= frac_a;
      sat_b  <= sat_a;

      prod_c <= step * frac_b;
      a_c    <= rd_a;

      t_d    <= a_c + prod_c[TQ+FB-1:FB];

      pt_e   <= threshold * t_d;

      qx_f   <= pt_e[W+TQ-2:TQ] * RECIP[S-1:0];
    end
  end

  assign out_valid = v[5];
  assign tag_out   = tg[5];
  assign soft_mag  = {1'b0, qx_f[W+S-2:S]};

endmodule
`default_nettype wire

FILE: design/audio_clipping_distortion.sv
`default_nettype none
// Clipping distortion for a stream of signed samples. One sample enters per
// clock unless the output stalls, and leaves with its last mark after 4
// stages of abs, gain and hard clip, 20 stages of a one-bit-per-stage
// divider that forms the tanh argument 3*gain*|x|/threshold (|x| after hard
// clip), 6 stages of table read, interpolation and scaling by threshold/3,
// and the output register. A stall on the output holds every stage; nothing
// is dropped. Bit0 of effect_enables turns on hard clipping, bit1 soft
// clipping after it. Write configuration only while the pipeline is empty.
module audio_clipping_distortion_core #(
  parameter int unsigned SAMPLE_WIDTH     = 24,
  parameter int unsigned TANH_TABLE_DEPTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  input  wire logic                                 last_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]            sample_out,
  output logic                                      last_out,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [acd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [acd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned W = SAMPLE_WIDTH;

  logic [1:0]                  effect_enables;
  logic [acd_pkg::GAIN_W-1:0]  gain;
  logic [W-2:0]                threshold;

  acd_pkg::stage_ctl_t ctl;
  logic                advance;

  logic                        f_valid;
  logic [W+17:0]               f_num;
  logic [W+1:0]                f_tag;
  logic                        d_valid;
  logic [acd_pkg::FRAC_BITS-1:0] d_quot;
  logic                        d_sat;
  logic [W+1:0]                d_tag;
  logic                        t_valid;
  logic [W-1:0]                t_soft;
  logic [W+1:0]                t_tag;
  logic [W-1:0]                mag_sel;
  logic [W-1:0]                res;
  logic [W-1:0]                out_u;
  logic [W-1:0]                out_mag;

  assign advance     = !out_valid || out_ready;
  assign in_ready    = advance;
  assign cfg_ready   = 1'b1;
  assign ctl.advance = advance;
  assign ctl.hard_en = effect_enables[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_enables <= 2'd0;
      gain           <= acd_pkg::GAIN_RESET;
      threshold      <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        acd_pkg::REG_EFFECT_ENABLES: effect_enables <= cfg_data[1:0];
        acd_pkg::REG_GAIN:           gain <= cfg_data[acd_pkg::GAIN_W-1:0];
        acd_pkg::REG_THRESHOLD:      threshold <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  acd_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .sample_in (sample_in),
    .last_in   (last_in),
    .gain      (gain),
    .threshold (threshold),
    .out_valid (f_valid),
    .num       (f_num),
    .tag       (f_tag)
  );

  acd_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (f_valid),
    .num       (f_num),
    .tag_in    (f_tag),
    .threshold (threshold),
    .out_valid (d_valid),
    .quot      (d_quot),
    .sat       (d_sat),
    .tag_out   (d_tag)
  );

  acd_tanh #(.W(W), .DEPTH(TANH_TABLE_DEPTH)) u_tanh (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (d_valid),
    .u         (d_quot),
    .sat       (d_sat),
    .tag_in    (d_tag),
    .threshold (threshold),
    .out_valid (t_valid),
    .soft_mag  (t_soft),
    .tag_out   (t_tag)
  );

  // tag carries {last, sign, magnitude after hard clip}
  assign mag_sel = effect_enables[1] ? t_soft : t_tag[W-1:0];
  assign res     = t_tag[W] ? (~mag_sel + {{(W-1){1'b0}}, 1'b1}) : mag_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= res;
      last_out   <= t_tag[W+1];
    end
  end

  assign out_u   = sample_out;
  assign out_mag = out_u[W-1] ? (~out_u + {{(W-1){1'b0}}, 1'b1}) : out_u;

`ifndef SYNTHESIS
  a_hard_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && effect_enables == 2'b01) |-> (out_mag <= {1'b0, threshold}))
    else $error("hard clip output exceeds threshold");

  a_soft_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && effect_enables[1]) |->
      ((W+2)'(out_mag) * 3 <= (W+2)'(threshold)))
    else $error("soft clip output exceeds one third of threshold");

  a_zero_thr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && threshold == '0 && effect_enables != 2'b00) |-> (out_u == '0))
    else $error("zero threshold gave nonzero output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |->
      (!in_ready ##1 (out_valid && $stable(t_tag) && $stable(sample_out))))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire
